### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/drs_pkg.sv
`default_nettype none
package drs_pkg;
  localparam int MaxPoints = 16;
  localparam int CoordBits = 16;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = $clog2(MaxPoints + 1);
  localparam int DistW = 34;
  localparam int LabelW = 4;
  localparam int QDepth = 2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] REG_OFFSET_X = 2'd0;
  localparam logic [1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [1:0] REG_OFFSET_Z = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic [LabelW-1:0] point_label;
    logic signed [CoordBits-1:0] coord_x;
    logic signed [CoordBits-1:0] coord_y;
    logic signed [CoordBits-1:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic [LabelW-1:0] ranked_label;
    logic [DistW-1:0]  distance_squared;
    logic              last;
  } out_item_t;

  // Classified work handed from front to back
  typedef struct packed {
    logic              is_query;
    logic [LabelW-1:0] label;
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
    logic signed [CoordBits-1:0] z;
  } work_t;

  typedef struct packed {
    logic push;
  } q_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIST, ST_ACC, ST_INSERT, ST_EMIT
  } back_state_t;

  function automatic logic signed [CoordBits-1:0] sat_add(
    input logic signed [CoordBits-1:0] a, input logic signed [CoordBits-1:0] b);
    logic signed [CoordBits:0] s;
    s = {a[CoordBits-1], a} + {b[CoordBits-1], b};
    if (s[CoordBits] != s[CoordBits-1])
      return s[CoordBits] ? {1'b1, {(CoordBits-1){1'b0}}} : {1'b0, {(CoordBits-1){1'b1}}};
    return s[CoordBits-1:0];
  endfunction
endpackage
`default_nettype wire

### rtl/core/drs_front.sv
`default_nettype none
module drs_front import drs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_take,
  input  wire in_item_t in_item,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [CoordBits-1:0] cfg_data,
  output q_ctl_t ctl,
  output work_t work
);
  logic signed [CoordBits-1:0] off_x_r, off_y_r, off_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0;
      off_y_r <= '0;
      off_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET_X: off_x_r <= cfg_data;
        REG_OFFSET_Y: off_y_r <= cfg_data;
        REG_OFFSET_Z: off_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Offset and clamp the target here so the back end sees final coordinates
  always_comb begin
    ctl.push = in_take;
    work.is_query = (in_item.cmd == CMD_QUERY);
    work.label = in_item.point_label;
    if (in_item.cmd == CMD_QUERY) begin
      work.x = sat_add(in_item.coord_x, off_x_r);
      work.y = sat_add(in_item.coord_y, off_y_r);
      work.z = sat_add(in_item.coord_z, off_z_r);
    end else begin
      work.x = in_item.coord_x;
      work.y = in_item.coord_y;
      work.z = in_item.coord_z;
    end
  end
endmodule
`default_nettype wire

### rtl/core/drs_queue.sv
`default_nettype none
module drs_queue import drs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire work_t wdata,
  input  wire logic pop,
  output logic empty,
  output logic full,
  output work_t rdata
);
  localparam int PW = $clog2(QDepth);
  work_t mem_r [QDepth];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0] cnt_r;
  logic do_push, do_pop;

  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      case ({do_push, do_pop})
        2'b10: cnt_r <= cnt_r + 1'b1;
        2'b01: cnt_r <= cnt_r - 1'b1;
        default: ;
      endcase
    end
  end

  assign empty = (cnt_r == '0);
  assign full = (cnt_r == (PW+1)'(QDepth));
  assign rdata = mem_r[rp_r];
endmodule
`default_nettype wire

### rtl/core/drs_back.sv
`default_nettype none
module drs_back import drs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_empty,
  input  wire work_t q_data,
  output logic q_pop,
  output logic out_valid,
  output out_item_t out_item,
  output logic busy_back
);
  // Point table, rank list
  logic signed [CoordBits-1:0] px_r [MaxPoints];
  logic signed [CoordBits-1:0] py_r [MaxPoints];
  logic signed [CoordBits-1:0] pz_r [MaxPoints];
  logic [LabelW-1:0] pl_r [MaxPoints];
  logic [DistW-1:0] rd_r [MaxPoints];
  logic [LabelW-1:0] rl_r [MaxPoints];
  logic [CntW-1:0] count_r, count_nxt;
  logic [CntW-1:0] idx_r, idx_nxt;
  logic [CntW-1:0] n_r, n_nxt;
  back_state_t st_r, st_nxt;
  work_t cur_r, cur_nxt;
  logic [2*CoordBits-1:0] sq_r [3];
  logic [DistW-1:0] d_r, d_nxt;
  logic out_valid_nxt;
  out_item_t out_nxt;
  logic [IdxW-1:0] ip;
  logic signed [CoordBits:0] dx, dy, dz;
  logic [CoordBits-1:0] ax, ay, az;

  assign ip = idx_r[IdxW-1:0];
  always_comb begin
    dx = {px_r[ip][CoordBits-1], px_r[ip]} - {cur_r.x[CoordBits-1], cur_r.x};
    dy = {py_r[ip][CoordBits-1], py_r[ip]} - {cur_r.y[CoordBits-1], cur_r.y};
    dz = {pz_r[ip][CoordBits-1], pz_r[ip]} - {cur_r.z[CoordBits-1], cur_r.z};
    // Magnitude never exceeds the unsigned coordinate range
    ax = dx[CoordBits] ? CoordBits'(-dx) : dx[CoordBits-1:0];
    ay = dy[CoordBits] ? CoordBits'(-dy) : dy[CoordBits-1:0];
    az = dz[CoordBits] ? CoordBits'(-dz) : dz[CoordBits-1:0];
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_DIST) begin
      sq_r[0] <= (2*CoordBits)'(ax) * (2*CoordBits)'(ax);
      sq_r[1] <= (2*CoordBits)'(ay) * (2*CoordBits)'(ay);
      sq_r[2] <= (2*CoordBits)'(az) * (2*CoordBits)'(az);
    end
    if (st_r == ST_IDLE && !q_empty && !q_data.is_query &&
        count_r < CntW'(MaxPoints)) begin
      px_r[count_r[IdxW-1:0]] <= q_data.x;
      py_r[count_r[IdxW-1:0]] <= q_data.y;
      pz_r[count_r[IdxW-1:0]] <= q_data.z;
      pl_r[count_r[IdxW-1:0]] <= q_data.label;
    end
    // Insertion: shift larger entries up one place, stable on ties
    if (st_r == ST_INSERT) begin
      if (n_r == '0 || d_r < rd_r[0]) begin
        rd_r[0] <= d_r;
        rl_r[0] <= pl_r[ip];
      end
      for (int m = 1; m < MaxPoints; m++) begin
        if (CntW'(m) <= n_r) begin
          if (d_r < rd_r[m-1]) begin
            rd_r[m] <= rd_r[m-1];
            rl_r[m] <= rl_r[m-1];
          end else if (CntW'(m) == n_r || d_r < rd_r[m]) begin
            rd_r[m] <= d_r;
            rl_r[m] <= pl_r[ip];
          end
        end
      end
    end
    cur_r <= cur_nxt;
    d_r <= d_nxt;
    out_item <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      count_r <= '0;
      idx_r <= '0;
      n_r <= '0;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      count_r <= count_nxt;
      idx_r <= idx_nxt;
      n_r <= n_nxt;
      out_valid <= out_valid_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    count_nxt = count_r;
    idx_nxt = idx_r;
    n_nxt = n_r;
    cur_nxt = cur_r;
    d_nxt = d_r;
    q_pop = 1'b0;
    out_valid_nxt = 1'b0;
    out_nxt = out_item;
    unique case (st_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          cur_nxt = q_data;
          if (!q_data.is_query) begin
            if (count_r < CntW'(MaxPoints)) count_nxt = count_r + 1'b1;
          end else if (count_r != '0) begin
            idx_nxt = '0;
            n_nxt = '0;
            st_nxt = ST_DIST;
          end
        end
      end
      ST_DIST: st_nxt = ST_ACC;
      ST_ACC: begin
        d_nxt = DistW'(sq_r[0]) + DistW'(sq_r[1]) + DistW'(sq_r[2]);
        st_nxt = ST_INSERT;
      end
      ST_INSERT: begin
        n_nxt = n_r + 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r + 1'b1 == count_r) begin
          idx_nxt = '0;
          st_nxt = ST_EMIT;
        end else begin
          st_nxt = ST_DIST;
        end
      end
      ST_EMIT: begin
        out_valid_nxt = 1'b1;
        out_nxt.ranked_label = rl_r[ip];
        out_nxt.distance_squared = rd_r[ip];
        out_nxt.last = (idx_r + 1'b1 == n_r);
        idx_nxt = idx_r + 1'b1;
        if (idx_r + 1'b1 == n_r) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign busy_back = (st_r != ST_IDLE);
endmodule
`default_nettype wire

### rtl/core/distance_rank_sorter_unit.sv
// Channel | Ports                        | Handshake
// input   | start, busy, in_item         | taken when start && !busy
// result  | out_valid, out_item          | one result per cycle, no stall
// config  | cfg_we, cfg_index, cfg_data  | written when cfg_we
// A load passes through the queue and is written to the point table without leaving idle.
// A query leaves the queue, then takes three steps per stored point (squares, sum,
// insertion) and emits its results from the rank list through one output register.
// rst_n is synchronous; the point table is left unwritten by reset.
// The result side cannot stall; busy holds off start while the queue is full.
`default_nettype none
`include "assert_macros.svh"
module distance_rank_sorter_unit import drs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire in_item_t in_item,
  output logic out_valid,
  output out_item_t out_item,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [CoordBits-1:0] cfg_data
);
  q_ctl_t ctl;
  work_t fw, qd;
  logic q_empty, q_full, q_pop, busy_back;

  assign busy = q_full;

  drs_front u_front (
    .clk, .rst_n, .in_take(start && !busy), .in_item,
    .cfg_we, .cfg_index, .cfg_data, .ctl, .work(fw)
  );

  drs_queue u_queue (
    .clk, .rst_n, .push(ctl.push), .wdata(fw), .pop(q_pop),
    .empty(q_empty), .full(q_full), .rdata(qd)
  );

  drs_back u_back (
    .clk, .rst_n, .q_empty, .q_data(qd), .q_pop, .out_valid, .out_item, .busy_back
  );

  `ASSERT_IMPLIES(a_no_pop_empty, clk, rst_n, q_pop, !q_empty)
  `ASSERT_IMPLIES(a_out_while_busy, clk, rst_n, out_valid && !out_item.last, busy_back)
  `ASSERT_NEXT(a_last_ends, clk, rst_n, out_valid && out_item.last, !out_valid)
endmodule
`default_nettype wire
